// ===== hdl/multichannel_homeostatic_level_tracker_defines.svh =====
// Assertion macros used by the checker of the level tracker.
`ifndef MULTICHANNEL_HOMEOSTATIC_LEVEL_TRACKER_DEFINES_SVH
`define MULTICHANNEL_HOMEOSTATIC_LEVEL_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mhlt_pkg.sv =====
package mhlt_pkg;

  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int LEVEL_BITS_DEF    = 16;

  // Item kinds.
  localparam logic [1:0] ITEM_TICK      = 2'd0;
  localparam logic [1:0] ITEM_SAMPLE    = 2'd1;
  localparam logic [1:0] ITEM_CONSENSUS = 2'd2;
  localparam logic [1:0] ITEM_EVENT     = 2'd3;

  // Event codes.
  localparam logic [2:0] EV_HIT    = 3'd0;
  localparam logic [2:0] EV_MISS   = 3'd1;
  localparam logic [2:0] EV_ALIVE  = 3'd2;
  localparam logic [2:0] EV_FAILED = 3'd3;

  // Channel kinds.
  localparam logic [2:0] KIND_ENERGY    = 3'd0;
  localparam logic [2:0] KIND_INTEGRITY = 3'd1;
  localparam logic [2:0] KIND_NOVELTY   = 3'd2;
  localparam logic [2:0] KIND_PASSIVE   = 3'd3;
  localparam logic [2:0] KIND_ALIVE     = 3'd4;

  // Register indexes.
  localparam logic [2:0] CFG_KIND     = 3'd0;
  localparam logic [2:0] CFG_SETPOINT = 3'd1;
  localparam logic [2:0] CFG_INV_NORM = 3'd2;
  localparam logic [2:0] CFG_ENERGY   = 3'd3;
  localparam logic [2:0] CFG_INTEG    = 3'd4;
  localparam logic [2:0] CFG_ALIVE    = 3'd5;
  localparam logic [2:0] CFG_SMOOTH   = 3'd6;
  localparam logic [2:0] CFG_CLAMP    = 3'd7;

  localparam logic [63:0] SETPOINT_RST = 64'h4000_4000_4000_4000;
  localparam logic [63:0] INV_NORM_RST = 64'h0100_0100_0100_0100;
  localparam logic [31:0] ENERGY_RST   = 32'h6666_0021;
  localparam logic [15:0] INTEG_RST    = 16'd3277;
  localparam logic [31:0] ALIVE_RST    = 32'h8000_0148;
  localparam logic [15:0] SMOOTH_RST   = 16'd66;
  localparam logic [31:0] CLAMP_RST    = 32'h8000_0000;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [11:0] kind_tbl;
    logic [63:0] setpoint;
    logic [63:0] inv_norm;
    logic [31:0] energy;
    logic [15:0] integ;
    logic [31:0] alive;
    logic [15:0] smooth;
    logic [31:0] clamp;
  } cfg_t;

endpackage

// ===== hdl/mhlt_cfg.sv =====
module mhlt_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output mhlt_pkg::cfg_t     cfg_o
);
  import mhlt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind_tbl <= '0;
      cfg_q.setpoint <= SETPOINT_RST;
      cfg_q.inv_norm <= INV_NORM_RST;
      cfg_q.energy   <= ENERGY_RST;
      cfg_q.integ    <= INTEG_RST;
      cfg_q.alive    <= ALIVE_RST;
      cfg_q.smooth   <= SMOOTH_RST;
      cfg_q.clamp    <= CLAMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KIND:     cfg_q.kind_tbl <= cfg_data_i[11:0];
        CFG_SETPOINT: cfg_q.setpoint <= cfg_data_i;
        CFG_INV_NORM: cfg_q.inv_norm <= cfg_data_i;
        CFG_ENERGY:   cfg_q.energy   <= cfg_data_i[31:0];
        CFG_INTEG:    cfg_q.integ    <= cfg_data_i[15:0];
        CFG_ALIVE:    cfg_q.alive    <= cfg_data_i[31:0];
        CFG_SMOOTH:   cfg_q.smooth   <= cfg_data_i[15:0];
        CFG_CLAMP:    cfg_q.clamp    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mhlt_mul.sv =====
module mhlt_mul (
  input  logic                          clk_i,
  input  mhlt_pkg::mul_req_t            req_i,
  output logic [mhlt_pkg::MUL_P_W-1:0]  prod_o
);
  import mhlt_pkg::*;

  logic [MUL_P_W-1:0] prod_q;

  // Registered product; it holds until the next request.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= {{MUL_B_W{1'b0}}, req_i.a} * {{MUL_A_W{1'b0}}, req_i.b};
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/multichannel_homeostatic_level_tracker.sv =====
// Multichannel level tracker. Channel samples, the consensus sample and events
// are each only latched when taken while idle; event counters stop at 255. A
// tick walks the channels in order, and each channel passes through a small
// sequencer that drives one shared 24 x 17 bit multiplier: prepare the level,
// two multiply steps for the kind-specific update, apply, one multiply for
// the urgency, then hand the result to the output register. A tick therefore
// holds the input until every channel is through, including any wait of the
// output register for a consumer. One result per channel
// carries the signed level error against the setpoint; the last result of a
// tick also carries the clamped maximum urgency, zero on the others. After a
// tick all sample valid flags and event counters are cleared. Configuration
// is written through a plain write port and should only change while idle.
module multichannel_homeostatic_level_tracker #(
  parameter int CHANNEL_COUNT = mhlt_pkg::CHANNEL_COUNT_DEF,
  parameter int LEVEL_BITS    = mhlt_pkg::LEVEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [1:0]         channel_index_i,
  input  logic [15:0]        sample_level_i,
  input  logic [2:0]         event_code_i,
  input  logic [31:0]        tick_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         result_channel_o,
  output logic signed [16:0] level_error_o,
  output logic [15:0]        urgency_level_o,
  output logic [31:0]        result_tick_o,
  output logic               last_of_tick_o
);
  import mhlt_pkg::*;

  localparam logic [15:0] LevelMask = 16'((32'd1 << LEVEL_BITS) - 32'd1);
  localparam logic [1:0]  LastChan  = 2'(CHANNEL_COUNT - 1);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PREP  = 3'd1;
  localparam logic [2:0] PH_M1    = 3'd2;
  localparam logic [2:0] PH_M2    = 3'd3;
  localparam logic [2:0] PH_APPLY = 3'd4;
  localparam logic [2:0] PH_URG   = 3'd5;
  localparam logic [2:0] PH_OUT   = 3'd6;

  cfg_t               cfg;
  mul_req_t           mreq;
  logic [MUL_P_W-1:0] prod;

  mhlt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mhlt_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  logic [2:0]  state_q;
  logic [1:0]  ch_q;
  logic [15:0] level_q [4];
  logic [15:0] samp_q  [4];
  logic [3:0]  sv_q;
  logic [15:0] cons_q;
  logic        cv_q;
  logic [7:0]  cnt_q   [4];
  logic [31:0] tick_q;
  logic [15:0] work_q;
  logic [33:0] acc_q;
  logic signed [16:0] err_q;
  logic [15:0] umax_q;

  logic        ov_q;
  logic [1:0]  oc_q;
  logic signed [16:0] oe_q;
  logic [15:0] ou_q;
  logic [31:0] ot_q;
  logic        ol_q;

  // Per-channel view of the configuration.
  logic [2:0]  ck;
  logic [15:0] sp, inv;
  logic        is_en, is_int, is_nov, is_alv, failed;
  logic [15:0] drain_e, drain_a, lvl_sel, prep_lvl, diff, new_lvl, mag, umax_new, clamped;
  logic [25:0] refill_sum;
  logic [24:0] drop;
  logic [33:0] nov_sum, u_wide;
  logic        out_free, accept;

  assign ck     = cfg.kind_tbl[ch_q*3 +: 3];
  assign sp     = cfg.setpoint[ch_q*16 +: 16] & LevelMask;
  assign inv    = cfg.inv_norm[ch_q*16 +: 16];
  assign is_en  = (ck == KIND_ENERGY);
  assign is_int = (ck == KIND_INTEGRITY);
  assign is_nov = (ck == KIND_NOVELTY);
  assign is_alv = (ck == KIND_ALIVE);
  assign failed = (cnt_q[EV_FAILED[1:0]] != 8'd0);

  assign drain_e = 16'(({2'b00, cfg.energy[15:0]} + 18'd2) >> 2);
  assign drain_a = 16'(({2'b00, cfg.alive[15:0]} + 18'd2) >> 2);

  assign out_free = !ov_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    // All but novelty and alive channels take a fresh sample first.
    lvl_sel = (sv_q[ch_q] && !is_nov && !is_alv) ? samp_q[ch_q] : level_q[ch_q];
    if (is_en) begin
      prep_lvl = (lvl_sel > drain_e) ? lvl_sel - drain_e : 16'd0;
    end else if (is_alv) begin
      prep_lvl = (failed || lvl_sel <= drain_a) ? 16'd0 : lvl_sel - drain_a;
    end else begin
      prep_lvl = lvl_sel;
    end

    diff = (sp > work_q) ? sp - work_q : 16'd0;

    // Error magnitude, fed to the multiplier in the urgency step.
    mag = err_q[16] ? 16'(-err_q) : err_q[15:0];

    mreq = '0;
    case (state_q)
      PH_M1: begin
        mreq.en = 1'b1;
        if (is_en) begin
          mreq.a = MUL_A_W'(cnt_q[EV_HIT[1:0]]);
          mreq.b = MUL_B_W'(cfg.energy[31:16]);
        end else if (is_alv) begin
          mreq.a = MUL_A_W'(cnt_q[EV_ALIVE[1:0]]);
          mreq.b = MUL_B_W'(cfg.alive[31:16]);
        end else if (is_int) begin
          mreq.a = MUL_A_W'(cnt_q[EV_MISS[1:0]]);
          mreq.b = MUL_B_W'(cfg.integ);
        end else begin
          mreq.a = MUL_A_W'(work_q);
          mreq.b = 17'h10000 - {1'b0, cfg.smooth};
        end
      end
      PH_M2: begin
        mreq.en = 1'b1;
        if (is_nov) begin
          mreq.a = MUL_A_W'(cons_q);
          mreq.b = MUL_B_W'(cfg.smooth);
        end else begin
          mreq.a = prod[MUL_A_W-1:0];
          mreq.b = MUL_B_W'(diff);
        end
      end
      PH_URG: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(mag);
        mreq.b  = MUL_B_W'(inv);
      end
      default: ;
    endcase

    // Apply step.
    refill_sum = 26'(work_q) + 26'((prod[39:0] + 40'h8000) >> 16);
    drop       = 25'(({1'b0, acc_q[23:0]} + 25'd2) >> 2);
    nov_sum    = acc_q + prod[33:0] + 34'h8000;
    new_lvl    = work_q;
    if ((is_en || (is_alv && !failed)) && sp > work_q) begin
      new_lvl = (refill_sum > 26'(sp)) ? sp : refill_sum[15:0];
    end else if (is_int) begin
      new_lvl = (25'(work_q) > drop) ? work_q - drop[15:0] : 16'd0;
    end else if (is_nov && cv_q) begin
      new_lvl = nov_sum[31:16];
    end
    new_lvl = new_lvl & LevelMask;

    u_wide   = (prod[33:0] + 34'd64) >> 7;
    umax_new = umax_q;
    if (u_wide > 34'hFFFF) begin
      umax_new = 16'hFFFF;
    end else if (u_wide[15:0] > umax_q) begin
      umax_new = u_wide[15:0];
    end
    // Lower clamp first; the upper clamp wins when the two cross.
    clamped = (umax_new < cfg.clamp[15:0]) ? cfg.clamp[15:0] : umax_new;
    clamped = (clamped > cfg.clamp[31:16]) ? cfg.clamp[31:16] : clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      ch_q    <= '0;
      sv_q    <= '0;
      cv_q    <= 1'b0;
      cons_q  <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        level_q[i] <= SETPOINT_RST[i*16 +: 16] & LevelMask;
        samp_q[i]  <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      // The output step reloads the register itself when it hands over a result.
      if (ov_q && out_ready_i && state_q != PH_OUT) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        PH_IDLE: begin
          if (accept) begin
            case (kind_i)
              ITEM_TICK: begin
                tick_q  <= tick_number_i;
                ch_q    <= '0;
                umax_q  <= '0;
                state_q <= PH_PREP;
              end
              ITEM_SAMPLE: begin
                if (32'(channel_index_i) < CHANNEL_COUNT) begin
                  samp_q[channel_index_i] <= sample_level_i & LevelMask;
                  sv_q[channel_index_i]   <= 1'b1;
                end
              end
              ITEM_CONSENSUS: begin
                cons_q <= sample_level_i & LevelMask;
                cv_q   <= 1'b1;
              end
              ITEM_EVENT: begin
                if (event_code_i <= EV_FAILED && cnt_q[event_code_i[1:0]] != 8'hFF) begin
                  cnt_q[event_code_i[1:0]] <= cnt_q[event_code_i[1:0]] + 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
        PH_PREP: begin
          work_q  <= prep_lvl;
          state_q <= PH_M1;
        end
        PH_M1: state_q <= PH_M2;
        PH_M2: begin
          acc_q   <= prod[33:0];
          state_q <= PH_APPLY;
        end
        PH_APPLY: begin
          level_q[ch_q] <= new_lvl;
          err_q         <= $signed({1'b0, new_lvl}) - $signed({1'b0, sp});
          state_q       <= PH_URG;
        end
        PH_URG: state_q <= PH_OUT;
        PH_OUT: begin
          if (out_free) begin
            umax_q <= umax_new;
            ov_q   <= 1'b1;
            oc_q   <= ch_q;
            oe_q   <= err_q;
            ot_q   <= tick_q;
            ol_q   <= (ch_q == LastChan);
            ou_q   <= (ch_q == LastChan) ? clamped : 16'd0;
            if (ch_q == LastChan) begin
              sv_q    <= '0;
              cv_q    <= 1'b0;
              for (int i = 0; i < 4; i++) begin
                cnt_q[i] <= '0;
              end
              state_q <= PH_IDLE;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= PH_PREP;
            end
          end
        end
        default: state_q <= PH_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == PH_IDLE);
  assign out_valid_o      = ov_q;
  assign result_channel_o = oc_q;
  assign level_error_o    = oe_q;
  assign urgency_level_o  = ou_q;
  assign result_tick_o    = ot_q;
  assign last_of_tick_o   = ol_q;

endmodule

// ===== hdl/mhlt_checker.sv =====
`include "multichannel_homeostatic_level_tracker_defines.svh"

module mhlt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] urgency_level_o,
  input logic [31:0] result_tick_o,
  input logic        last_of_tick_o
);
  import mhlt_pkg::*;

  // A stalled result keeps its tick.
  `MHLT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_tick_o), "stalled result changed")
  // Only the last result of a tick carries urgency.
  `MHLT_ASSERT_SAME(a_urg_last, out_valid_o && !last_of_tick_o, urgency_level_o == 16'd0, "urgency on a non-last result")
  // The block is only idle again once the last result of a tick is out.
  `MHLT_ASSERT_SAME(a_idle_last, out_valid_o && in_ready_o, last_of_tick_o, "idle with a non-last result pending")
  // An accepted tick makes the block busy.
  `MHLT_ASSERT_NEXT(a_tick_busy, in_valid_i && in_ready_o && kind_i == ITEM_TICK, !in_ready_o, "tick did not start work")

endmodule

bind multichannel_homeostatic_level_tracker mhlt_checker u_mhlt_checker (.*);

// ===== tb/tb_multichannel_homeostatic_level_tracker.sv =====
`timescale 1ns / 100ps

module tb_multichannel_homeostatic_level_tracker;
  import mhlt_pkg::*;

  // One tick of the block walks four channels through the sequencer. A further
  // margin covers the output register, so DRAIN_CYCLES of quiet are plenty.
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 144;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         kind_i;
  logic [1:0]         channel_index_i;
  logic [15:0]        sample_level_i;
  logic [2:0]         event_code_i;
  logic [31:0]        tick_number_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         result_channel_o;
  logic signed [16:0] level_error_o;
  logic [15:0]        urgency_level_o;
  logic [31:0]        result_tick_o;
  logic               last_of_tick_o;

  multichannel_homeostatic_level_tracker uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .channel_index_i (channel_index_i),
    .sample_level_i  (sample_level_i),
    .event_code_i    (event_code_i),
    .tick_number_i   (tick_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_channel_o(result_channel_o),
    .level_error_o   (level_error_o),
    .urgency_level_o (urgency_level_o),
    .result_tick_o   (result_tick_o),
    .last_of_tick_o  (last_of_tick_o)
  );

  // One channel report as the block should send it.
  typedef struct {
    logic [1:0]         chan;
    logic signed [16:0] err;
    logic [15:0]        urg;
    logic [31:0]        tick;
    logic               last;
  } report_t;

  // A row of the directed table: either an input item or a register write.
  // When check_typed is set, the error of channel 0 and the urgency of the
  // tick are also held against values worked out by hand.
  typedef struct {
    logic               is_cfg;
    logic [2:0]         reg_idx;
    logic [63:0]        reg_val;
    logic [1:0]         kind;
    logic [1:0]         chan;
    logic [15:0]        sample;
    logic [2:0]         code;
    logic [31:0]        tick;
    logic               check_typed;
    logic signed [16:0] typed_err0;
    logic [15:0]        typed_urg;
  } row_t;

  report_t pending_reports[$];
  bit      failed;
  int      cycle_count;
  int      sender_idle_pct;
  int      receiver_stall_pct;

  // Shadow of the block: configuration and tracked state.
  cfg_t        shadow_cfg;
  int unsigned level_q[4];
  int unsigned sample_q[4];
  bit          sample_seen[4];
  int unsigned consensus_q;
  bit          consensus_latched;
  int unsigned event_count[4];

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multichannel_homeostatic_level_tracker verification failed");
      $finish;
    end
  end

  function automatic int unsigned sub_floor(int unsigned lvl, int unsigned d);
    return (lvl > d) ? lvl - d : 0;
  endfunction

  // Moves a level toward its setpoint by count times a fraction of the gap.
  function automatic int unsigned top_up(int unsigned lvl, int unsigned sp,
                                         int unsigned cnt, int unsigned frac);
    longint unsigned gain;
    longint unsigned sum;
    if (cnt == 0 || sp <= lvl) return lvl;
    gain = (longint'(cnt) * frac * (sp - lvl) + 64'h8000) >> 16;
    sum  = longint'(lvl) + gain;
    return (sum > sp) ? sp : int'(sum);
  endfunction

  function automatic void reset_shadow();
    shadow_cfg = '{kind_tbl: '0, setpoint: SETPOINT_RST, inv_norm: INV_NORM_RST,
                   energy: ENERGY_RST, integ: INTEG_RST, alive: ALIVE_RST,
                   smooth: SMOOTH_RST, clamp: CLAMP_RST};
    for (int c = 0; c < 4; c++) begin
      level_q[c]     = SETPOINT_RST[16*c +: 16];
      sample_q[c]    = 0;
      sample_seen[c] = 0;
      event_count[c] = 0;
    end
    consensus_q       = 0;
    consensus_latched = 0;
  endfunction

  function automatic void shadow_write(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_KIND:     shadow_cfg.kind_tbl = val[11:0];
      CFG_SETPOINT: shadow_cfg.setpoint = val;
      CFG_INV_NORM: shadow_cfg.inv_norm = val;
      CFG_ENERGY:   shadow_cfg.energy   = val[31:0];
      CFG_INTEG:    shadow_cfg.integ    = val[15:0];
      CFG_ALIVE:    shadow_cfg.alive    = val[31:0];
      CFG_SMOOTH:   shadow_cfg.smooth   = val[15:0];
      CFG_CLAMP:    shadow_cfg.clamp    = val[31:0];
      default: ;
    endcase
  endfunction

  // Works out the reports of one tick and advances the shadow state.
  function automatic void track_tick(logic [31:0] tick);
    int unsigned     lvl, sp, mag, peak, lo, hi, a;
    longint unsigned acc;
    logic [2:0]      ck;
    int              err;
    report_t         rep;
    peak = 0;
    for (int c = 0; c < 4; c++) begin
      ck  = shadow_cfg.kind_tbl[3*c +: 3];
      sp  = shadow_cfg.setpoint[16*c +: 16];
      lvl = level_q[c];
      case (ck)
        KIND_ENERGY: begin
          if (sample_seen[c]) lvl = sample_q[c];
          lvl = sub_floor(lvl, (shadow_cfg.energy[15:0] + 2) >> 2);
          lvl = top_up(lvl, sp, event_count[EV_HIT], shadow_cfg.energy[31:16]);
        end
        KIND_INTEGRITY: begin
          if (sample_seen[c]) lvl = sample_q[c];
          if (event_count[EV_MISS] > 0)
            lvl = sub_floor(lvl, (event_count[EV_MISS] * shadow_cfg.integ + 2) >> 2);
        end
        KIND_NOVELTY: begin
          if (consensus_latched) begin
            a   = shadow_cfg.smooth;
            acc = longint'(65536 - a) * lvl + longint'(a) * consensus_q + 64'h8000;
            lvl = int'(acc >> 16);
          end
        end
        KIND_ALIVE: begin
          // A failure report empties the channel for this tick.
          if (event_count[EV_FAILED] > 0) begin
            lvl = 0;
          end else begin
            lvl = sub_floor(lvl, (shadow_cfg.alive[15:0] + 2) >> 2);
            lvl = top_up(lvl, sp, event_count[EV_ALIVE], shadow_cfg.alive[31:16]);
          end
        end
        default: begin
          // Passive channels, and the unused kind codes with them.
          if (sample_seen[c]) lvl = sample_q[c];
        end
      endcase
      lvl        = lvl & 32'hFFFF;
      level_q[c] = lvl;
      err = int'(lvl) - int'(sp);
      mag = (err < 0) ? -err : err;
      acc = (longint'(mag) * shadow_cfg.inv_norm[16*c +: 16] + 64) >> 7;
      if (acc > 64'hFFFF) acc = 64'hFFFF;
      if (int'(acc) > peak) peak = int'(acc);
      rep = '{chan: c[1:0], err: err[16:0], urg: '0, tick: tick, last: 1'b0};
      if (c == 3) begin
        lo = shadow_cfg.clamp[15:0];
        hi = shadow_cfg.clamp[31:16];
        if (peak < lo) peak = lo;
        if (peak > hi) peak = hi;
        rep.urg  = peak[15:0];
        rep.last = 1'b1;
      end
      pending_reports = {pending_reports, rep};
    end
    for (int c = 0; c < 4; c++) begin
      sample_seen[c] = 0;
      event_count[c] = 0;
    end
    consensus_latched = 0;
  endfunction

  // Follows every accepted item and every register write.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) shadow_write(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (kind_i)
        ITEM_SAMPLE: begin
          sample_q[channel_index_i]    = sample_level_i;
          sample_seen[channel_index_i] = 1;
        end
        ITEM_CONSENSUS: begin
          consensus_q       = sample_level_i;
          consensus_latched = 1;
        end
        ITEM_EVENT: begin
          if (event_code_i <= EV_FAILED && event_count[event_code_i] < 255)
            event_count[event_code_i]++;
        end
        default: track_tick(tick_number_i);
      endcase
    end
  end

  // Checks each result the block hands over against the oldest expectation.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result channel %0d error %0d", $time,
                 result_channel_o, level_error_o);
        failed = 1;
      end else begin
        want = pending_reports.pop_front();
        if (result_channel_o !== want.chan) begin
          $display("%0t: channel expected %0d actual %0d", $time, want.chan,
                   result_channel_o);
          failed = 1;
        end
        if (level_error_o !== want.err) begin
          $display("%0t: level error ch %0d expected %0d actual %0d", $time,
                   want.chan, want.err, level_error_o);
          failed = 1;
        end
        if (urgency_level_o !== want.urg) begin
          $display("%0t: urgency ch %0d expected %0h actual %0h", $time, want.chan,
                   want.urg, urgency_level_o);
          failed = 1;
        end
        if (result_tick_o !== want.tick) begin
          $display("%0t: tick expected %0h actual %0h", $time, want.tick,
                   result_tick_o);
          failed = 1;
        end
        if (last_of_tick_o !== want.last) begin
          $display("%0t: last flag ch %0d expected %0b actual %0b", $time,
                   want.chan, want.last, last_of_tick_o);
          failed = 1;
        end
      end
    end
  end

  // The consumer stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Presents one item, with random idle cycles ahead of it, and holds it
  // until the block takes it. Valid stays high afterward until the next
  // falling edge decides whether another item follows.
  task automatic offer_item(logic [1:0] kind, logic [1:0] chan, logic [15:0] sample,
                            logic [2:0] code, logic [31:0] tick);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    channel_index_i <= chan;
    sample_level_i  <= sample;
    event_code_i    <= code;
    tick_number_i   <= tick;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lets the block run dry: no item offered, every report in, then quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Register values: a quarter all zeros, a quarter all ones, the rest random.
  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random traffic. Most items build up samples and events ahead of a tick.
  task automatic random_traffic(int count);
    int         pick;
    logic [2:0] code;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      code = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
      if (pick < 35)
        offer_item(ITEM_SAMPLE, 2'($urandom), 16'($urandom), 3'($urandom), $urandom);
      else if (pick < 50)
        offer_item(ITEM_CONSENSUS, 2'($urandom), 16'($urandom), 3'($urandom), $urandom);
      else if (pick < 80)
        offer_item(ITEM_EVENT, 2'($urandom), 16'($urandom), code, $urandom);
      else
        offer_item(ITEM_TICK, 2'($urandom), 16'($urandom), 3'($urandom), $urandom);
    end
  endtask

  row_t directed[$];

  function automatic void add_row(row_t r);
    directed = {directed, r};
  endfunction

  function automatic row_t item_row(logic [1:0] kind, logic [1:0] chan,
                                    logic [15:0] sample, logic [2:0] code,
                                    logic [31:0] tick);
    return '{is_cfg: 0, reg_idx: CFG_KIND, reg_val: '0, kind: kind, chan: chan,
             sample: sample, code: code, tick: tick, check_typed: 0,
             typed_err0: '0, typed_urg: '0};
  endfunction

  function automatic row_t reg_row(logic [2:0] idx, logic [63:0] val);
    row_t r;
    r = item_row(ITEM_TICK, '0, '0, EV_HIT, '0);
    r.is_cfg  = 1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t tick_row(logic [31:0] tick, logic signed [16:0] err0,
                                    logic [15:0] urg);
    row_t r;
    r = item_row(ITEM_TICK, '0, '0, EV_HIT, tick);
    r.check_typed = 1;
    r.typed_err0  = err0;
    r.typed_urg   = urg;
    return r;
  endfunction

  initial begin
    row_t    r;
    report_t first_rep;
    report_t last_rep;
    clk_i = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = CFG_KIND;
    cfg_data_i = '0;
    in_valid_i = 0;
    kind_i = ITEM_TICK;
    channel_index_i = '0;
    sample_level_i = '0;
    event_code_i = EV_HIT;
    tick_number_i = '0;
    out_ready_i = 0;
    failed = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    reset_shadow();

    // Directed part. All channels start as energy channels at setpoint.
    // The first tick after reset drains every channel by eight, so the error
    // is minus eight and the urgency sixteen.
    add_row(tick_row(32'h0000_0001, -17'sd8, 16'h0010));
    // A full-scale sample drains by eight, far above setpoint: the urgency
    // saturates and is held to the upper clamp of one half.
    add_row(item_row(ITEM_SAMPLE, 2'd0, 16'hFFFF, EV_HIT, '0));
    add_row(tick_row(32'hFFFF_FFFF, 17'sd49143, 16'h8000));
    // A zero sample sits at the floor, a full setpoint below.
    add_row(item_row(ITEM_SAMPLE, 2'd0, 16'h0000, EV_HIT, '0));
    add_row(tick_row(32'h0000_0002, -17'sd16384, 16'h8000));
    // Kinds: energy, integrity, novelty, alive pulse.
    add_row(reg_row(CFG_KIND, {52'd0, KIND_ALIVE, KIND_NOVELTY,
                               KIND_INTEGRITY, KIND_ENERGY}));
    add_row(item_row(ITEM_EVENT, 2'd0, '0, EV_HIT, '0));
    add_row(item_row(ITEM_EVENT, 2'd1, '0, EV_HIT, '0));
    add_row(item_row(ITEM_EVENT, 2'd2, '0, EV_MISS, '0));
    add_row(item_row(ITEM_EVENT, 2'd3, '0, EV_ALIVE, '0));
    add_row(item_row(ITEM_SAMPLE, 2'd1, 16'h2000, EV_HIT, '0));
    add_row(item_row(ITEM_CONSENSUS, 2'd0, 16'hFFFF, EV_HIT, '0));
    // Event codes above failed are dropped.
    add_row(item_row(ITEM_EVENT, 2'd0, '0, 3'd4, '0));
    add_row(item_row(ITEM_EVENT, 2'd0, '0, 3'd7, '0));
    add_row(item_row(ITEM_TICK, 2'd0, '0, EV_HIT, 32'h1234_5678));
    // A failure report empties the alive channel.
    add_row(item_row(ITEM_EVENT, 2'd0, '0, EV_FAILED, '0));
    add_row(item_row(ITEM_TICK, 2'd3, '0, EV_HIT, 32'h8000_0000));
    // Unused kind codes behave as passive; zero normalizers silence the
    // urgency, and crossed clamps let the upper clamp win. Channel 0 keeps
    // the level left by the two hits and one more drain.
    add_row(reg_row(CFG_KIND, {52'd0, 3'd7, 3'd6, 3'd5, KIND_PASSIVE}));
    add_row(reg_row(CFG_INV_NORM, 64'h0000_FFFF_0000_FFFF));
    add_row(reg_row(CFG_CLAMP, 32'h0100_7FFF));
    add_row(item_row(ITEM_SAMPLE, 2'd2, 16'hABCD, EV_HIT, '0));
    add_row(item_row(ITEM_SAMPLE, 2'd3, 16'h0001, EV_HIT, '0));
    add_row(tick_row(32'h0000_0003, -17'sd3285, 16'h0100));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      r = directed[i];
      if (r.is_cfg) begin
        settle();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        offer_item(r.kind, r.chan, r.sample, r.code, r.tick);
        if (r.check_typed) begin
          // Let the shadow take the tick first; its four reports are queued last.
          #1;
          first_rep = pending_reports[pending_reports.size() - 4];
          last_rep  = pending_reports[pending_reports.size() - 1];
          if (first_rep.err !== r.typed_err0 || last_rep.urg !== r.typed_urg) begin
            $display("%0t: tick %0h expected error %0d urgency %0h, predicted %0d %0h",
                     $time, r.tick, r.typed_err0, r.typed_urg, first_rep.err,
                     last_rep.urg);
            failed = 1;
          end
        end
      end
    end

    // Random part in four phases, each under a fresh configuration.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase
      for (int idx = 0; idx < 8; idx++) begin
        if (phase == 0) write_reg(3'(idx), '1);
        else write_reg(3'(idx), pick_reg_value());
      end
      // Integrity channels everywhere, so a full miss counter shows up.
      if (phase == 2) begin
        write_reg(CFG_KIND, {52'd0, {4{KIND_INTEGRITY}}});
        write_reg(CFG_INTEG, 64'd1);
        for (int n = 0; n < 260; n++) offer_item(ITEM_EVENT, '0, '0, EV_MISS, '0);
        offer_item(ITEM_TICK, '0, '0, EV_HIT, $urandom);
      end
      random_traffic(RANDOM_ITEMS / 8);
      // Hold the producer back until every report has come, then go on.
      if (phase == 1) settle();
      random_traffic(RANDOM_ITEMS / 8);
    end

    settle();
    if (!failed) begin
      $display("multichannel_homeostatic_level_tracker verification clean");
    end else begin
      $display("multichannel_homeostatic_level_tracker verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mhlt_pkg.sv
hdl/mhlt_cfg.sv
hdl/mhlt_mul.sv
hdl/multichannel_homeostatic_level_tracker.sv
hdl/mhlt_checker.sv
tb/tb_multichannel_homeostatic_level_tracker.sv
